// ===== rtl/extent_map_lookup_assert.svh =====
// assertion macros for the extent map lookup block
// depends on nothing; included by the top level only
`ifndef EXTENT_MAP_LOOKUP_ASSERT_SVH
`define EXTENT_MAP_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define EML_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define EML_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) else $error(msg);
`else
`define EML_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define EML_NEVER(lbl, clk_s, rst_s, expr, msg)
`endif
`endif

// ===== rtl/eml_pkg.sv =====
// shared types and constants for the extent map lookup block
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package eml_pkg;

  localparam int MAX_EXTENTS_DEF = 256;

  localparam int ENTRY_IDX_W = 8;
  localparam int BLOCK_W     = 24;
  localparam int LEN_W       = 8;
  localparam int PHYS_W      = 25;
  localparam int COUNT_W     = 9;

  // function codes of an input transaction
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_MAPPED   = 2'd0,
    ST_HOLE     = 2'd1,
    ST_PAST_END = 2'd2
  } status_t;

  // one table entry as stored
  typedef struct packed {
    logic [BLOCK_W-1:0] lstart;
    logic [LEN_W-1:0]   len;
    logic [BLOCK_W-1:0] pstart;
  } extent_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic start;
    logic step;
    logic load_out;
  } eml_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } eml_sts_t;

endpackage

`default_nettype wire

// ===== rtl/eml_if.sv =====
// channel interfaces of the extent map lookup block
// depends on eml_pkg for field widths and the status type
`default_nettype none

interface eml_in_if import eml_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [BLOCK_W-1:0]     entry_logical_start;
  logic [LEN_W-1:0]       entry_length;
  logic [BLOCK_W-1:0]     entry_physical_start;
  logic [BLOCK_W-1:0]     lookup_block;

  modport source (
    output valid, func, entry_index, entry_logical_start, entry_length,
           entry_physical_start, lookup_block,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_logical_start, entry_length,
           entry_physical_start, lookup_block,
    output ready
  );
endinterface

interface eml_out_if import eml_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [PHYS_W-1:0] physical_block;

  modport source (output valid, status, physical_block, input ready);
  modport sink (input valid, status, physical_block, output ready);
endinterface

interface eml_cfg_if import eml_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] extent_count;

  modport source (output valid, extent_count, input ready);
  modport sink (input valid, extent_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/eml_ctrl.sv =====
// controller of the extent map lookup: accepts transactions, steps the scan
// depends on eml_pkg for the command and status structs and function codes
`default_nettype none

module eml_ctrl import eml_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_func,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire eml_sts_t sts,
  output eml_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_func == FUNC_WRITE) begin
          cmd.wr_en = 1'b1;
        end
        if (in_valid && in_func == FUNC_LOOKUP) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/eml_dp.sv =====
// datapath of the extent map lookup: extent table, scan pointer, compare, result register
// depends on eml_pkg for widths, the entry layout and the command and status structs
`default_nettype none

module eml_dp import eml_pkg::*; #(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire eml_cmd_t               cmd,
  output eml_sts_t                    sts,
  input  wire logic [ENTRY_IDX_W-1:0] entry_index,
  input  wire logic [BLOCK_W-1:0]     entry_logical_start,
  input  wire logic [LEN_W-1:0]       entry_length,
  input  wire logic [BLOCK_W-1:0]     entry_physical_start,
  input  wire logic [BLOCK_W-1:0]     lookup_block,
  input  wire logic                   cfg_we,
  input  wire logic [COUNT_W-1:0]     cfg_count,
  output status_t                     out_status,
  output logic [PHYS_W-1:0]           out_physical_block
);

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int WI_W  = (CNT_W > ENTRY_IDX_W) ? CNT_W : ENTRY_IDX_W;
  localparam int LIM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  extent_t              mem [MAX_EXTENTS];
  extent_t              rdata_r;
  logic [COUNT_W-1:0]   extent_count_r;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [BLOCK_W-1:0]   blk_r;
  status_t              out_status_r, res_status;
  logic [PHYS_W-1:0]    out_phys_r, res_phys;
  logic [WI_W-1:0]      wr_idx;
  logic                 wr_ok;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [LIM_W-1:0]     cnt_ext;
  logic [BLOCK_W-1:0]   offset;
  logic                 at_end, below, hit;

  // write slot decode, slots beyond the table are dropped
  assign wr_idx  = WI_W'(entry_index);
  assign wr_ok   = wr_idx < WI_W'(MAX_EXTENTS);
  assign wr_addr = wr_idx[IDX_W-1:0];

  // scan length is the count clipped to the table size
  assign cnt_ext   = LIM_W'(extent_count_r);
  assign limit_nxt = (cnt_ext > LIM_W'(MAX_EXTENTS)) ? CNT_W'(MAX_EXTENTS)
                                                     : CNT_W'(cnt_ext);

  // scan pointer, read address follows its next value
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.start) begin
      pos_nxt = '0;
    end else if (cmd.step) begin
      pos_nxt = pos_r + CNT_W'(1);
    end
  end
  assign rd_addr = pos_nxt[IDX_W-1:0];

  // extent table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[wr_addr] <= '{lstart: entry_logical_start, len: entry_length,
                        pstart: entry_physical_start};
    end
    rdata_r <= mem[rd_addr];
  end

  // compare the block against the entry under the pointer
  always_comb begin
    at_end     = (pos_r >= limit_r);
    below      = (blk_r < rdata_r.lstart);
    offset     = blk_r - rdata_r.lstart;
    hit        = (offset < BLOCK_W'(rdata_r.len));
    res_status = ST_PAST_END;
    res_phys   = '0;
    if (at_end) begin
      res_status = ST_PAST_END;
    end else if (below) begin
      res_status = ST_HOLE;
    end else if (hit) begin
      res_status = ST_MAPPED;
      res_phys   = PHYS_W'(rdata_r.pstart) + PHYS_W'(offset);
    end
    sts.done = at_end || below || hit;
  end

  // lookup context and result register
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.start) begin
      blk_r   <= lookup_block;
      limit_r <= limit_nxt;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status;
      out_phys_r   <= res_phys;
    end
  end

  // extent count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extent_count_r <= '0;
    end else if (cfg_we) begin
      extent_count_r <= cfg_count;
    end
  end

  assign out_status         = out_status_r;
  assign out_physical_block = out_phys_r;

endmodule

`default_nettype wire

// ===== rtl/extent_map_lookup.sv =====
// top level of the extent map lookup block: channels, controller and datapath
// depends on eml_pkg, eml_if, eml_ctrl, eml_dp and extent_map_lookup_assert.svh
`default_nettype none
`include "extent_map_lookup_assert.svh"

// Maps a logical block to a physical block through a table of up to
// MAX_EXTENTS extents held in one single-port-read memory. A write transaction
// (func 0) stores one entry and gives no result. A lookup (func 1) scans
// entries from slot 0 at one memory read per cycle and stops at the first
// entry that maps the block or starts beyond it, or past the last of
// n = min(extent_count, MAX_EXTENTS) entries. The input stays busy from the
// accept until the result is loaded, also while it waits for an untaken
// earlier result. The result sits in an output register, so new transactions
// are taken while it waits; a lookup that ends while the previous result is
// still untaken waits for it. Entries must be written before a lookup reaches
// them. extent_count is written through the configuration channel, which is
// always ready.
module extent_map_lookup import eml_pkg::*; #(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  eml_in_if.sink    in_ch,
  eml_out_if.source out_ch,
  eml_cfg_if.sink   cfg_ch
);

  eml_cmd_t cmd;
  eml_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // transaction control
  eml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and scan
  eml_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .entry_index          (in_ch.entry_index),
    .entry_logical_start  (in_ch.entry_logical_start),
    .entry_length         (in_ch.entry_length),
    .entry_physical_start (in_ch.entry_physical_start),
    .lookup_block         (in_ch.lookup_block),
    .cfg_we               (cfg_ch.valid),
    .cfg_count            (cfg_ch.extent_count),
    .out_status           (out_ch.status),
    .out_physical_block   (out_ch.physical_block)
  );

  // checks
  `EML_ASSERT(a_busy_after_lookup, clk, rst_n, cmd.start |=> !in_ch.ready, "input ready while a lookup scans")
  `EML_ASSERT(a_valid_from_load, clk, rst_n, $rose(out_ch.valid) |-> $past(cmd.load_out), "result valid without a load")
  `EML_NEVER(a_write_in_scan, clk, rst_n, cmd.wr_en && (cmd.step || cmd.load_out), "table write during a scan")
  `EML_NEVER(a_load_over_result, clk, rst_n, cmd.load_out && out_ch.valid && !out_ch.ready, "result overwritten before taken")

endmodule

`default_nettype wire

// ===== tb/tb_extent_map_lookup.sv =====
`timescale 1ns / 1ps
// self-checking testbench for extent_map_lookup: a directed table, then randomised phases
// of sorted extent layouts, with lookups checked against an in-bench mapping predictor
// depends on eml_pkg and the channel interfaces in eml_if

module tb_extent_map_lookup;
  import eml_pkg::*;

  localparam int DIR_ROWS = 24;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic               func;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [BLOCK_W-1:0] ls;
    logic [LEN_W-1:0]   len;
    logic [BLOCK_W-1:0] ps;
    logic [BLOCK_W-1:0] blk;
  } eml_req_t;

  typedef struct packed {
    status_t           st;
    logic [PHYS_W-1:0] pb;
  } block_map_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_LOOKUP, ROW_CFG} row_kind_t;

  // one row of the directed table; chk selects the typed-in result over the predictor
  typedef struct packed {
    row_kind_t              kind;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [BLOCK_W-1:0]     ls;
    logic [LEN_W-1:0]       len;
    logic [BLOCK_W-1:0]     ps;
    logic [BLOCK_W-1:0]     blk;
    logic [COUNT_W-1:0]     cnt;
    logic                   chk;
    status_t                st;
    logic [PHYS_W-1:0]      pb;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // nothing to scan straight after reset
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'h000000, '0, 1'b1, ST_PAST_END, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'hFFFFFF, '0, 1'b1, ST_PAST_END, '0},
    // field extremes, a zero-length extent and the last slot
    '{ROW_WRITE, 8'd0, 24'd10, 8'd5, 24'hFFFFFF, '0, '0, 1'b0, ST_MAPPED, '0},
    '{ROW_WRITE, 8'd1, 24'd20, 8'd0, 24'h123456, '0, '0, 1'b0, ST_MAPPED, '0},
    '{ROW_WRITE, 8'd2, 24'd20, 8'd255, 24'h000000, '0, '0, 1'b0, ST_MAPPED, '0},
    '{ROW_WRITE, 8'd3, 24'hFFFFFF, 8'd255, 24'hFFFFFF, '0, '0, 1'b0, ST_MAPPED, '0},
    '{ROW_WRITE, 8'd255, 24'h000000, 8'd0, 24'h000000, '0, '0, 1'b0, ST_MAPPED, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd10, '0, 1'b1, ST_PAST_END, '0},
    '{ROW_CFG, '0, '0, '0, '0, '0, 9'd4, 1'b0, ST_MAPPED, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd9, '0, 1'b1, ST_HOLE, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd10, '0, 1'b1, ST_MAPPED, 25'h0FFFFFF},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd14, '0, 1'b1, ST_MAPPED, 25'h1000003},
    // hole in front of the zero-length extent
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd15, '0, 1'b1, ST_HOLE, '0},
    // zero-length extent is stepped over
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd20, '0, 1'b1, ST_MAPPED, 25'd0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd274, '0, 1'b1, ST_MAPPED, 25'd254},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd275, '0, 1'b1, ST_HOLE, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'hFFFFFF, '0, 1'b1, ST_MAPPED, 25'h0FFFFFF},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd0, '0, 1'b1, ST_HOLE, '0},
    // zero-length extent as the last valid one
    '{ROW_CFG, '0, '0, '0, '0, '0, 9'd2, 1'b0, ST_MAPPED, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd20, '0, 1'b1, ST_PAST_END, '0},
    '{ROW_WRITE, 8'd0, 24'd0, 8'd255, 24'hABCDEF, '0, '0, 1'b0, ST_MAPPED, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd0, '0, 1'b1, ST_MAPPED, 25'h0ABCDEF},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd254, '0, 1'b0, ST_MAPPED, '0},
    '{ROW_LOOKUP, '0, '0, '0, '0, 24'd255, '0, 1'b1, ST_PAST_END, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic burst_on = 1'b0;

  eml_in_if  in_ch ();
  eml_out_if out_ch ();
  eml_cfg_if cfg_ch ();

  extent_map_lookup i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // bench copy of the extent table and count register
  extent_t            model_tbl [MAX_EXTENTS_DEF];
  logic [COUNT_W-1:0] model_count = '0;
  block_map_t         pending_maps [$];

  int mismatches = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int n_settings = 0;
  int n_mapped = 0;
  int n_holes = 0;
  int n_past_end = 0;
  int unsigned cycles = 0;

  always #4 clk = ~clk;

  // expected mapping of one logical block under the current table and count
  function automatic block_map_t map_block(input logic [BLOCK_W-1:0] blk);
    block_map_t res;
    logic [BLOCK_W-1:0] off;
    int lim;
    res = '{st: ST_PAST_END, pb: '0};
    lim = (int'(model_count) > MAX_EXTENTS_DEF) ? MAX_EXTENTS_DEF : int'(model_count);
    for (int i = 0; i < lim; i++) begin
      if (blk < model_tbl[i].lstart) begin
        res = '{st: ST_HOLE, pb: '0};
        return res;
      end
      off = blk - model_tbl[i].lstart;
      if (off < BLOCK_W'(model_tbl[i].len)) begin
        res.st = ST_MAPPED;
        res.pb = PHYS_W'(model_tbl[i].pstart) + PHYS_W'(off);
        return res;
      end
    end
    return res;
  endfunction

  function automatic eml_req_t random_req();
    eml_req_t req;
    req.func = 1'($urandom_range(1));
    req.idx  = ENTRY_IDX_W'($urandom);
    req.ls   = BLOCK_W'($urandom);
    req.len  = LEN_W'($urandom);
    req.ps   = BLOCK_W'($urandom);
    req.blk  = BLOCK_W'($urandom);
    return req;
  endfunction

  // drive one input transaction, then update the table or queue the expected mapping
  task automatic send_req(input eml_req_t req, input logic typed_in, input status_t typed_st,
                          input logic [PHYS_W-1:0] typed_pb);
    @(negedge clk);
    while (!burst_on && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid                <= 1'b1;
    in_ch.func                 <= req.func;
    in_ch.entry_index          <= req.idx;
    in_ch.entry_logical_start  <= req.ls;
    in_ch.entry_length         <= req.len;
    in_ch.entry_physical_start <= req.ps;
    in_ch.lookup_block         <= req.blk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (req.func == FUNC_WRITE) begin
      model_tbl[req.idx] = '{lstart: req.ls, len: req.len, pstart: req.ps};
      n_writes++;
    end else begin
      pending_maps.push_back(typed_in ? block_map_t'{st: typed_st, pb: typed_pb}
                                      : map_block(req.blk));
      n_lookups++;
    end
  endtask

  // stop sending and wait for the block to go quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_extent_count(input logic [COUNT_W-1:0] cnt);
    settle();
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.extent_count <= cnt;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    model_count = cnt;
    n_settings++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one count setting: a sorted layout over the scanned slots, then mixed traffic
  task automatic run_phase(input logic [COUNT_W-1:0] cnt, input int n_mixed);
    int n;
    int unsigned cursor;
    int unsigned r;
    eml_req_t req;
    extent_t e;
    logic [BLOCK_W-1:0] top;
    write_extent_count(cnt);
    n = (int'(cnt) > MAX_EXTENTS_DEF) ? MAX_EXTENTS_DEF : int'(cnt);
    cursor = $urandom_range(32'hFFFFFF - n * 300);
    for (int i = 0; i < n; i++) begin
      req = random_req();
      req.func = FUNC_WRITE;
      req.idx = ENTRY_IDX_W'(i);
      r = $urandom_range(99);
      cursor += (r < 30) ? 0 : $urandom_range(40, 1);
      req.ls = BLOCK_W'(cursor);
      r = $urandom_range(99);
      req.len = (r < 10) ? 8'd0 : (r < 20) ? 8'hFF : LEN_W'($urandom_range(254, 1));
      cursor += req.len;
      send_req(req, 1'b0, ST_MAPPED, '0);
    end
    top = BLOCK_W'(cursor);
    for (int k = 0; k < n_mixed; k++) begin
      req = random_req();
      r = $urandom_range(99);
      if (r < 10) begin
        // stray write to any slot, which may break the ordering
        req.func = FUNC_WRITE;
      end else begin
        req.func = FUNC_LOOKUP;
        if (n > 0 && r < 80) begin
          e = model_tbl[$urandom_range(n - 1)];
          if (r < 50)
            req.blk = BLOCK_W'(e.lstart + ((e.len == 0) ? 0 : $urandom_range(e.len - 1)));
          else if (r < 60)
            req.blk = BLOCK_W'(e.lstart + e.len);
          else if (r < 70)
            req.blk = BLOCK_W'(e.lstart - 1);
          else
            req.blk = BLOCK_W'(top + $urandom_range(2000));
        end
      end
      send_req(req, 1'b0, ST_MAPPED, '0);
    end
  endtask

  // result sink stalls at random unless in a burst stretch
  always @(negedge clk) begin
    out_ch.ready <= burst_on || ($urandom_range(99) >= 9);
  end

  // compare every result transaction with the oldest expected mapping
  always @(posedge clk) begin
    block_map_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: result with none expected: status %0d block %h", $time,
                 out_ch.status, out_ch.physical_block);
        mismatches++;
      end else begin
        want = pending_maps.pop_front();
        if (out_ch.status !== want.st || out_ch.physical_block !== want.pb) begin
          $display("%0t: expected status %0d block %h, got status %0d block %h", $time,
                   want.st, want.pb, out_ch.status, out_ch.physical_block);
          mismatches++;
        end
        case (want.st)
          ST_MAPPED: n_mapped++;
          ST_HOLE:   n_holes++;
          default:   n_past_end++;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time,
               pending_maps.size());
      $display("tb_extent_map_lookup failed");
      $finish;
    end
  end

  initial begin
    eml_req_t req;
    dir_row_t row;
    logic [COUNT_W-1:0] cnt;
    int ph;
    for (int i = 0; i < MAX_EXTENTS_DEF; i++) model_tbl[i] = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_logical_start = '0;
    in_ch.entry_length = '0;
    in_ch.entry_physical_start = '0;
    in_ch.lookup_block = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.extent_count = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_extent_count(row.cnt);
      end else begin
        req = random_req();
        if (row.kind == ROW_WRITE) begin
          req.func = FUNC_WRITE;
          req.idx = row.idx;
          req.ls = row.ls;
          req.len = row.len;
          req.ps = row.ps;
        end else begin
          req.func = FUNC_LOOKUP;
          req.blk = row.blk;
        end
        send_req(req, row.chk, row.st, row.pb);
      end
    end

    // random phases: count extremes first, then mostly short tables
    ph = 0;
    while (n_writes + n_lookups < DIR_ROWS + RANDOM_ITEMS) begin
      case (ph)
        0: cnt = 9'd0;
        1: cnt = 9'd1;
        2: cnt = 9'd256;
        3: cnt = 9'd511;
        default: cnt = ($urandom_range(99) < 10) ? COUNT_W'($urandom_range(256, 17))
                                                 : COUNT_W'($urandom_range(16));
      endcase
      burst_on = (ph == 6 || ph == 7);
      run_phase(cnt, (cnt > 64) ? 40 : 80);
      ph++;
    end
    burst_on = 1'b0;

    settle();
    $display("covered %0d table writes and %0d lookups over %0d count settings",
             n_writes, n_lookups, n_settings);
    $display("lookup outcomes: %0d mapped, %0d holes, %0d past end",
             n_mapped, n_holes, n_past_end);
    if (mismatches == 0) begin
      $display("tb_extent_map_lookup passed");
    end else begin
      $display("tb_extent_map_lookup failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/eml_pkg.sv
rtl/eml_if.sv
rtl/eml_ctrl.sv
rtl/eml_dp.sv
rtl/extent_map_lookup.sv
tb/tb_extent_map_lookup.sv
